[rtl/core/rss_pkg.sv]
`timescale 1ns / 1ps

package rss_pkg;

    localparam int DEF_MAX_LEN = 16;
    localparam int MAX_RESULTS = 32;
    localparam int CHAR_W      = 16;

    typedef enum logic [1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_CONS    = 2'd1,
        CLS_VOWEL   = 2'd2,
        CLS_SIGN    = 2'd3
    } cls_t;

    localparam logic [CHAR_W-1:0] CODE_OPEN  = 16'h005B;
    localparam logic [CHAR_W-1:0] CODE_CLOSE = 16'h005D;
    localparam logic [CHAR_W-1:0] CYR_LOW_FIRST = 16'h0430;
    localparam logic [CHAR_W-1:0] CYR_LOW_LAST  = 16'h044F;

    // Classes of the lowercase Cyrillic block, one entry per code from 0x430 upward.
    localparam cls_t LETTER_CLASS [32] = '{
        CLS_VOWEL, CLS_CONS,  CLS_CONS,  CLS_CONS,  CLS_CONS,  CLS_VOWEL, CLS_CONS,  CLS_CONS,
        CLS_VOWEL, CLS_VOWEL, CLS_CONS,  CLS_CONS,  CLS_CONS,  CLS_CONS,  CLS_VOWEL, CLS_CONS,
        CLS_CONS,  CLS_CONS,  CLS_CONS,  CLS_VOWEL, CLS_CONS,  CLS_CONS,  CLS_CONS,  CLS_CONS,
        CLS_CONS,  CLS_CONS,  CLS_SIGN,  CLS_VOWEL, CLS_SIGN,  CLS_VOWEL, CLS_VOWEL, CLS_VOWEL
    };

    function automatic logic [CHAR_W-1:0] to_lower(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 16'h0041 && c <= 16'h005A) begin
            r = c + 16'h0020;
        end else if (c >= 16'h0410 && c <= 16'h042F) begin
            r = c + 16'h0020;
        end else if (c >= 16'h0400 && c <= 16'h040F) begin
            r = c + 16'h0050;
        end
        return r;
    endfunction

    function automatic cls_t class_of(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        cls_t r;
        off = c - CYR_LOW_FIRST;
        r = CLS_UNKNOWN;
        if (c >= CYR_LOW_FIRST && c <= CYR_LOW_LAST) begin
            r = LETTER_CLASS[off[4:0]];
        end
        return r;
    endfunction

endpackage

[rtl/core/rss_ram.sv]
`timescale 1ns / 1ps

module rss_ram import rss_pkg::*; #(
    parameter int WIDTH = CHAR_W,
    parameter int DEPTH = DEF_MAX_LEN,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/russian_syllable_splitter.sv]
`timescale 1ns / 1ps

// Channel  Ports                                                        Word
// input    s_valid s_ready s_char_code s_word_end                       one character
// result   m_valid m_ready m_out_code m_out_last m_unsplit m_overflow   one output character
//
// Characters load one per cycle into the word RAM; nothing comes out until the last one.
// After the last character, S_FETCH reads the first entry, then one result leaves per
// cycle while m_ready is high: the single RAM read port is read one character ahead.
// Input is not taken while a word drains; the result register holds under a stall.
// aresetn is synchronous and active low; it clears the FSM, counts, cut bits and m_valid.

module russian_syllable_splitter import rss_pkg::*; #(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [CHAR_W-1:0] s_char_code,
    input  logic              s_word_end,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [CHAR_W-1:0] m_out_code,
    output logic              m_out_last,
    output logic              m_unsplit,
    output logic              m_overflow
);

    localparam int IW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);
    localparam int CW = $clog2(MAX_RESULTS);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FETCH,
        S_CLOSE_MID,
        S_OPEN,
        S_CHAR,
        S_CLOSE_END
    } state_t;

    state_t             state_reg, state_next;
    logic [LW-1:0]      len_reg, len_next;
    cls_t               prev_cls_reg, prev_cls_next;
    logic               invalid_reg, invalid_next;
    logic               trunc_reg, trunc_next;
    logic               first_done_reg, first_done_next;
    logic               word0_vowel_reg, word0_vowel_next;
    logic [IW-1:0]      cons_pos_reg, cons_pos_next;
    logic [MAX_LEN-1:0] cut_reg, cut_next;
    logic [IW-1:0]      k_reg, k_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]  out_code_reg, out_code_next;
    logic               out_last_reg, out_last_next;
    logic               unsplit_reg, unsplit_next;
    logic               overflow_reg, overflow_next;

    logic              in_fire;
    logic [CHAR_W-1:0] lc;
    cls_t              lcls;
    logic              has_room;
    logic              out_free;
    logic              k_is_last;
    logic [IW-1:0]     k_inc;
    logic              split;
    logic              emit_valid;
    logic              emit_last;
    logic [CHAR_W-1:0] emit_code;
    logic              ram_rd_en;
    logic [IW-1:0]     ram_rd_addr;
    logic [CHAR_W-1:0] rd_data;

    assign s_ready   = (state_reg == S_LOAD);
    assign in_fire   = s_valid && s_ready;
    assign lc        = to_lower(s_char_code);
    assign lcls      = class_of(lc);
    assign has_room  = (len_reg < LW'(MAX_LEN));
    assign out_free  = !m_valid_reg || m_ready;
    assign k_is_last = ((LW'(k_reg) + LW'(1)) == len_reg);
    assign k_inc     = k_reg + IW'(1);
    assign split     = !invalid_reg;

    always_comb begin
        emit_valid = 1'b0;
        emit_code  = CODE_CLOSE;
        unique case (state_reg)
            S_CLOSE_MID, S_CLOSE_END: begin
                emit_valid = out_free;
                emit_code  = CODE_CLOSE;
            end
            S_OPEN: begin
                emit_valid = out_free;
                emit_code  = CODE_OPEN;
            end
            S_CHAR: begin
                emit_valid = out_free;
                emit_code  = rd_data;
            end
            default: begin
                emit_valid = 1'b0;
            end
        endcase
        // The result count is capped; the capped result closes the word.
        emit_last = (state_reg == S_CLOSE_END)
                 || (state_reg == S_CHAR && !split && k_is_last)
                 || (cnt_reg == CW'(MAX_RESULTS - 1));
    end

    assign ram_rd_en   = (state_reg == S_FETCH)
                      || (state_reg == S_CHAR && emit_valid && !emit_last && !k_is_last);
    assign ram_rd_addr = (state_reg == S_FETCH) ? k_reg : k_inc;

    always_comb begin
        state_next       = state_reg;
        len_next         = len_reg;
        prev_cls_next    = prev_cls_reg;
        invalid_next     = invalid_reg;
        trunc_next       = trunc_reg;
        first_done_next  = first_done_reg;
        word0_vowel_next = word0_vowel_reg;
        cons_pos_next    = cons_pos_reg;
        cut_next         = cut_reg;
        k_next           = k_reg;
        cnt_next         = cnt_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        out_code_next = out_code_reg;
        out_last_next = out_last_reg;
        unsplit_next  = unsplit_reg;
        overflow_next = overflow_reg;

        if (emit_valid) begin
            m_valid_next  = 1'b1;
            out_code_next = emit_code;
            out_last_next = emit_last;
            unsplit_next  = invalid_reg;
            overflow_next = trunc_reg;
            cnt_next      = cnt_reg + CW'(1);
        end

        unique case (state_reg)
            S_LOAD: begin
                if (in_fire) begin
                    if (has_room) begin
                        len_next      = len_reg + LW'(1);
                        prev_cls_next = lcls;
                        if (lcls == CLS_UNKNOWN
                                || (lcls == CLS_SIGN && prev_cls_reg != CLS_CONS)) begin
                            invalid_next = 1'b1;
                        end
                        if (lcls == CLS_CONS) begin
                            cons_pos_next = len_reg[IW-1:0];
                        end
                        if (len_reg == '0) begin
                            word0_vowel_next = (lcls == CLS_VOWEL);
                        end
                        // A vowel after a consonant (or consonant plus sign) marks a
                        // syllable start at that consonant. The first such place only
                        // counts when the word opens with a vowel.
                        if (lcls == CLS_VOWEL
                                && (prev_cls_reg == CLS_CONS || prev_cls_reg == CLS_SIGN)) begin
                            first_done_next = 1'b1;
                            if (first_done_reg || word0_vowel_reg) begin
                                cut_next[cons_pos_reg] = 1'b1;
                            end
                        end
                    end else begin
                        trunc_next = 1'b1;
                    end
                    if (s_word_end) begin
                        state_next = S_FETCH;
                        k_next     = '0;
                        cnt_next   = '0;
                    end
                end
            end
            S_FETCH: begin
                state_next = split ? S_OPEN : S_CHAR;
            end
            S_OPEN: begin
                if (emit_valid) begin
                    state_next = emit_last ? S_LOAD : S_CHAR;
                end
            end
            S_CLOSE_MID: begin
                if (emit_valid) begin
                    state_next = emit_last ? S_LOAD : S_OPEN;
                end
            end
            S_CHAR: begin
                if (emit_valid) begin
                    if (emit_last) begin
                        state_next = S_LOAD;
                    end else if (k_is_last) begin
                        state_next = S_CLOSE_END;
                    end else begin
                        k_next     = k_inc;
                        state_next = (split && cut_reg[k_inc]) ? S_CLOSE_MID : S_CHAR;
                    end
                end
            end
            S_CLOSE_END: begin
                if (emit_valid) begin
                    state_next = S_LOAD;
                end
            end
            default: begin
                state_next = S_LOAD;
            end
        endcase

        // Leaving the drain returns the word state to empty.
        if (state_reg != S_LOAD && state_next == S_LOAD) begin
            len_next        = '0;
            prev_cls_next   = CLS_UNKNOWN;
            invalid_next    = 1'b0;
            trunc_next      = 1'b0;
            first_done_next = 1'b0;
            cut_next        = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_LOAD;
            len_reg        <= '0;
            prev_cls_reg   <= CLS_UNKNOWN;
            invalid_reg    <= 1'b0;
            trunc_reg      <= 1'b0;
            first_done_reg <= 1'b0;
            cut_reg        <= '0;
            cnt_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            len_reg        <= len_next;
            prev_cls_reg   <= prev_cls_next;
            invalid_reg    <= invalid_next;
            trunc_reg      <= trunc_next;
            first_done_reg <= first_done_next;
            cut_reg        <= cut_next;
            cnt_reg        <= cnt_next;
            m_valid_reg    <= m_valid_next;
        end
        word0_vowel_reg <= word0_vowel_next;
        cons_pos_reg    <= cons_pos_next;
        k_reg           <= k_next;
        out_code_reg    <= out_code_next;
        out_last_reg    <= out_last_next;
        unsplit_reg     <= unsplit_next;
        overflow_reg    <= overflow_next;
    end

    rss_ram #(
        .WIDTH(CHAR_W),
        .DEPTH(MAX_LEN)
    ) u_word_ram (
        .clk    (aclk),
        .wr_en  (in_fire && has_room),
        .wr_addr(len_reg[IW-1:0]),
        .wr_data(lc),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(rd_data)
    );

    assign m_valid    = m_valid_reg;
    assign m_out_code = out_code_reg;
    assign m_out_last = out_last_reg;
    assign m_unsplit  = unsplit_reg;
    assign m_overflow = overflow_reg;

`ifndef SYNTHESIS
    a_no_cut_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        !invalid_reg |-> !cut_reg[0])
        else $error("syllable cut marked at the first character");

    a_trunc_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        trunc_reg |-> (len_reg == LW'(MAX_LEN)))
        else $error("overflow flagged with room left in the word RAM");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit_valid && emit_last) |=> (len_reg == '0 && !trunc_reg && !invalid_reg
                                       && state_reg == S_LOAD))
        else $error("word state not cleared after the final result");

    a_char_held_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CHAR && $past(state_reg == S_CHAR && !emit_valid))
            |-> $stable(rd_data))
        else $error("RAM read data changed while a character waited");
`endif

endmodule
